// ===== hdl/tlst_pkg.sv =====
// shared types and reset values for the tick led sequencer tone generator
package tlst_pkg;

    // register file layout
    localparam int unsigned RegCount   = 5;
    localparam int unsigned AddrWidth  = 5;
    localparam int unsigned DataWidth  = 32;

    // register indexes
    localparam logic [2:0] REG_PHASE_TICKS = 3'd0;
    localparam logic [2:0] REG_BLINK_TICKS = 3'd1;
    localparam logic [2:0] REG_HOLD_TICKS  = 3'd2;
    localparam logic [2:0] REG_PITCH_LOW   = 3'd3;
    localparam logic [2:0] REG_PITCH_HIGH  = 3'd4;

    // reset values
    localparam logic [15:0] PHASE_TICKS_RST = 16'd3000;
    localparam logic [15:0] BLINK_TICKS_RST = 16'd10000;
    localparam logic [7:0]  HOLD_TICKS_RST  = 8'd50;
    localparam logic [31:0] PITCH_LOW_RST   = 32'h1C1E_2226;
    localparam logic [31:0] PITCH_HIGH_RST  = 32'h1214_1619;

    // drive bit masks
    localparam logic [4:0] TONE_BIT       = 5'h10;
    localparam logic [4:0] BLINK_LEFT     = 5'h08;
    localparam logic [4:0] BLINK_RIGHT    = 5'h01;
    localparam logic [2:0] PITCH_MAX      = 3'd7;

    // configuration seen by the datapath
    typedef struct packed {
        logic [15:0] phase_ticks;
        logic [15:0] blink_ticks;
        logic [7:0]  hold_ticks;
        logic [31:0] pitch_low;
        logic [31:0] pitch_high;
    } t_cfg;

endpackage

// ===== hdl/tick_led_sequencer_tone_generator_unit.sv =====
// Tick LED sequencer and tone generator. Each input transaction is one timer
// tick with the up, down and sound enable buttons; it advances the three-phase
// rotator, the two-side blinker, the pitch selector and the square-wave tone
// and yields one result transaction (port_value, pitch_index) on the next
// cycle from the result register. One tick is taken every cycle:
// a new tick is accepted whenever the result register is empty or its result
// is being taken in the same cycle, so o_stall only follows i_stall while a
// result waits. Configuration goes through the APB port and must be written
// only while no tick is in flight; the block itself does not enforce this.
module tick_led_sequencer_tone_generator_unit
    import tlst_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // tick channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_button_up,
    input  logic                 i_button_down,
    input  logic                 i_sound_enable,
    // result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [4:0]           o_port_value,
    output logic [2:0]           o_pitch_index,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [DataWidth-1:0] pwdata,
    output logic [DataWidth-1:0] prdata,
    output logic                 pready
);

    typedef enum logic [1:0] {
        SEL_IDLE = 2'd0,
        SEL_UP   = 2'd1,
        SEL_DOWN = 2'd2,
        SEL_WAIT = 2'd3
    } t_sel;

    t_cfg        w_cfg;
    logic        w_acc;

    logic [1:0]  r_phase, n_phase;
    logic [15:0] r_rot_cnt, n_rot_cnt;
    logic        r_side, n_side;
    logic [15:0] r_blink_cnt, n_blink_cnt;
    t_sel        r_sel, n_sel;
    logic [7:0]  r_hold_cnt, n_hold_cnt;
    logic [2:0]  r_pitch_sel, n_pitch_sel;
    logic        r_tone_high, n_tone_high;
    logic [7:0]  r_tone_cnt, n_tone_cnt;
    logic        r_out_valid;
    logic [4:0]  r_port_value, n_port_value;
    logic [2:0]  r_pitch_index;
    logic [31:0] w_word;
    logic [7:0]  w_half;

    tlst_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // handshake: take a tick unless a result is held back
    assign o_stall = r_out_valid & i_stall;
    assign w_acc   = i_valid & ~o_stall;

    // rotator
    always_comb begin
        n_phase   = r_phase;
        n_rot_cnt = r_rot_cnt;
        if (r_phase == 2'd3) begin
            n_phase = 2'd0;
        end else if (r_rot_cnt == w_cfg.phase_ticks) begin
            n_phase   = (r_phase == 2'd2) ? 2'd0 : r_phase + 2'd1;
            n_rot_cnt = '0;
        end
        n_rot_cnt = n_rot_cnt + 16'd1;
    end

    // blinker
    always_comb begin
        n_side      = r_side;
        n_blink_cnt = r_blink_cnt;
        if (r_blink_cnt == w_cfg.blink_ticks) begin
            n_side      = ~r_side;
            n_blink_cnt = '0;
        end
        n_blink_cnt = n_blink_cnt + 16'd1;
    end

    // pitch selector: transition, then the action of the new state
    always_comb begin
        n_sel       = r_sel;
        n_hold_cnt  = r_hold_cnt;
        n_pitch_sel = r_pitch_sel;
        case (r_sel)
            SEL_IDLE: begin
                if (i_button_up && !i_button_down) begin
                    n_sel = SEL_UP;
                end else if (i_button_down && !i_button_up) begin
                    n_sel = SEL_DOWN;
                end
            end
            SEL_UP, SEL_DOWN: n_sel = SEL_WAIT;
            default: begin
                if (r_hold_cnt >= w_cfg.hold_ticks && !i_button_up && !i_button_down) begin
                    n_sel = SEL_IDLE;
                end
            end
        endcase
        case (n_sel)
            SEL_IDLE: n_hold_cnt = '0;
            SEL_UP: begin
                if (r_pitch_sel != PITCH_MAX) begin
                    n_pitch_sel = r_pitch_sel + 3'd1;
                end
            end
            SEL_DOWN: begin
                if (r_pitch_sel != 3'd0) begin
                    n_pitch_sel = r_pitch_sel - 3'd1;
                end
            end
            default: n_hold_cnt = r_hold_cnt + 8'd1;
        endcase
    end

    // tone, half period from the updated pitch
    assign w_word = n_pitch_sel[2] ? w_cfg.pitch_high : w_cfg.pitch_low;
    assign w_half = w_word[{n_pitch_sel[1:0], 3'b000} +: 8];

    always_comb begin
        n_tone_high = r_tone_high;
        n_tone_cnt  = r_tone_cnt;
        if (r_tone_cnt == w_half) begin
            if (r_tone_high) begin
                n_tone_high = 1'b0;
                n_tone_cnt  = '0;
            end else if (i_sound_enable) begin
                n_tone_high = 1'b1;
                n_tone_cnt  = '0;
            end
        end
        n_tone_cnt = n_tone_cnt + 8'd1;
    end

    // combined drive bits
    always_comb begin
        n_port_value = {2'b00, 3'b001 << n_phase};
        n_port_value = n_port_value | (n_side ? BLINK_RIGHT : BLINK_LEFT);
        if (n_tone_high) begin
            n_port_value = n_port_value | TONE_BIT;
        end
    end

    // machine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 2'd0;
            r_rot_cnt   <= '0;
            r_side      <= 1'b0;
            r_blink_cnt <= '0;
            r_sel       <= SEL_IDLE;
            r_hold_cnt  <= '0;
            r_pitch_sel <= '0;
            r_tone_high <= 1'b1;
            r_tone_cnt  <= '0;
        end else if (w_acc) begin
            r_phase     <= n_phase;
            r_rot_cnt   <= n_rot_cnt;
            r_side      <= n_side;
            r_blink_cnt <= n_blink_cnt;
            r_sel       <= n_sel;
            r_hold_cnt  <= n_hold_cnt;
            r_pitch_sel <= n_pitch_sel;
            r_tone_high <= n_tone_high;
            r_tone_cnt  <= n_tone_cnt;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_port_value  <= n_port_value;
            r_pitch_index <= n_pitch_sel;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_port_value  = r_port_value;
    assign o_pitch_index = r_pitch_index;

    // an accepted tick always leaves a result behind
    a_acc_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> o_valid)
        else $error("accepted tick produced no result");

    // the shown pitch matches the selector state
    a_pitch_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch_index == r_pitch_sel))
        else $error("result pitch differs from selector state");

    // pitch moves by at most one step per tick
    a_pitch_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> (n_pitch_sel == r_pitch_sel || n_pitch_sel == r_pitch_sel + 3'd1
                   || n_pitch_sel == r_pitch_sel - 3'd1))
        else $error("pitch jumped by more than one step");

endmodule

// ===== hdl/tlst_regs.sv =====
// apb configuration register file
module tlst_regs
    import tlst_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [DataWidth-1:0] pwdata,
    output logic [DataWidth-1:0] prdata,
    output logic                 pready,
    output t_cfg                 o_cfg
);

    logic       w_wr;
    logic [2:0] w_idx;
    t_cfg       r_cfg;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[AddrWidth-1:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_ticks <= PHASE_TICKS_RST;
            r_cfg.blink_ticks <= BLINK_TICKS_RST;
            r_cfg.hold_ticks  <= HOLD_TICKS_RST;
            r_cfg.pitch_low   <= PITCH_LOW_RST;
            r_cfg.pitch_high  <= PITCH_HIGH_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_PHASE_TICKS: r_cfg.phase_ticks <= pwdata[15:0];
                REG_BLINK_TICKS: r_cfg.blink_ticks <= pwdata[15:0];
                REG_HOLD_TICKS:  r_cfg.hold_ticks  <= pwdata[7:0];
                REG_PITCH_LOW:   r_cfg.pitch_low   <= pwdata;
                REG_PITCH_HIGH:  r_cfg.pitch_high  <= pwdata;
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            REG_PHASE_TICKS: prdata = {16'd0, r_cfg.phase_ticks};
            REG_BLINK_TICKS: prdata = {16'd0, r_cfg.blink_ticks};
            REG_HOLD_TICKS:  prdata = {24'd0, r_cfg.hold_ticks};
            REG_PITCH_LOW:   prdata = r_cfg.pitch_low;
            REG_PITCH_HIGH:  prdata = r_cfg.pitch_high;
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for the tick led sequencer and tone generator unit
`timescale 1ns / 1ps

module tb_top;
    import tlst_pkg::*;

    localparam int unsigned CycleLimit = 400000;
    localparam int unsigned DirRows    = 22;

    typedef enum logic [1:0] {SEL_IDLE, SEL_UP, SEL_DOWN, SEL_WAIT} t_sel_state;
    typedef enum logic {ROW_TICK, ROW_WRITE} t_row_kind;

    typedef struct packed {
        logic [4:0] port_value;
        logic [2:0] pitch_index;
    } t_tick_result;

    typedef struct packed {
        t_row_kind    kind;
        logic [2:0]   reg_idx;
        logic [31:0]  data;
        logic         up;
        logic         dn;
        logic         en;
        logic         typed;
        t_tick_result want;
    } t_dir_row;

    // dut ports
    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_valid        = 1'b0;
    logic                 o_stall;
    logic                 i_button_up    = 1'b0;
    logic                 i_button_down  = 1'b0;
    logic                 i_sound_enable = 1'b0;
    logic                 o_valid;
    logic                 i_stall        = 1'b0;
    logic [4:0]           o_port_value;
    logic [2:0]           o_pitch_index;
    logic                 psel           = 1'b0;
    logic                 penable        = 1'b0;
    logic                 pwrite         = 1'b0;
    logic [AddrWidth-1:0] paddr          = '0;
    logic [DataWidth-1:0] pwdata         = '0;
    logic [DataWidth-1:0] prdata;
    logic                 pready;

    // predictor copy of the configuration and state
    t_cfg        model_cfg;
    logic [1:0]  rot_phase;
    logic [15:0] rot_count;
    logic        blink_right;
    logic [15:0] blink_count;
    t_sel_state  sel_state;
    logic [7:0]  hold_count;
    logic [2:0]  pitch_sel;
    logic        tone_on;
    logic [7:0]  tone_count;

    t_tick_result pending_results[$];
    int unsigned  mismatch_count = 0;
    int unsigned  readback_errs  = 0;
    int unsigned  ticks_sent     = 0;
    int unsigned  cycle_count    = 0;
    logic         tx_quiet       = 1'b0;
    logic         rx_quiet       = 1'b0;
    logic         hold_off_req   = 1'b0;

    // directed rows: typed results only right after reset and at the minimum pitch
    t_dir_row dir_table [DirRows] = '{
        '{ROW_TICK,  '0,               32'd0,          1'b0, 1'b0, 1'b0, 1'b1, '{5'h19, 3'd0}},
        '{ROW_TICK,  '0,               32'd0,          1'b0, 1'b1, 1'b0, 1'b1, '{5'h19, 3'd0}},
        '{ROW_WRITE, REG_PHASE_TICKS,  32'd2,          1'b0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_BLINK_TICKS,  32'd3,          1'b0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_HOLD_TICKS,   32'd0,          1'b0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_PITCH_LOW,    32'h0405_0603,  1'b0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_PITCH_HIGH,   32'h00FF_0201,  1'b0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_TICK,  '0,               32'd0,          1'b1, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_TICK,  '0,               32'd0,          1'b0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_TICK,  '0,               32'd0,          1'b1, 1'b1, 1'b1, 1'b0, '0},
        '{ROW_TICK,  '0,               32'd0,          1'b1, 1'b0, 1'b1, 1'b0, '0},
        '{ROW_TICK,  '0,               32'd0,          1'b1, 1'b0, 1'b1, 1'b0, '0},
        '{ROW_TICK,  '0,               32'd0,          1'b1, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_TICK,  '0,               32'd0,          1'b0, 1'b0, 1'b1, 1'b0, '0},
        '{ROW_TICK,  '0,               32'd0,          1'b1, 1'b0, 1'b1, 1'b0, '0},
        '{ROW_TICK,  '0,               32'd0,          1'b0, 1'b1, 1'b1, 1'b0, '0},
        '{ROW_TICK,  '0,               32'd0,          1'b0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_TICK,  '0,               32'd0,          1'b0, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_TICK,  '0,               32'd0,          1'b0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_TICK,  '0,               32'd0,          1'b0, 1'b0, 1'b1, 1'b0, '0},
        '{ROW_TICK,  '0,               32'd0,          1'b1, 1'b0, 1'b1, 1'b0, '0},
        '{ROW_TICK,  '0,               32'd0,          1'b0, 1'b0, 1'b1, 1'b0, '0}
    };

    tick_led_sequencer_tone_generator_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_button_up    (i_button_up),
        .i_button_down  (i_button_down),
        .i_sound_enable (i_sound_enable),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_port_value   (o_port_value),
        .o_pitch_index  (o_pitch_index),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CycleLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic pick_enable(input logic bias);
        return bias ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 9) == 0);
    endfunction

    // half period bytes drawn from a small range so the tone toggles often
    function automatic logic [31:0] small_table(input int unsigned top);
        logic [31:0] val;
        int          b;
        for (b = 0; b < 4; b++) val[8*b +: 8] = 8'($urandom_range(1, top));
        return val;
    endfunction

    task automatic reset_model();
        model_cfg.phase_ticks = PHASE_TICKS_RST;
        model_cfg.blink_ticks = BLINK_TICKS_RST;
        model_cfg.hold_ticks  = HOLD_TICKS_RST;
        model_cfg.pitch_low   = PITCH_LOW_RST;
        model_cfg.pitch_high  = PITCH_HIGH_RST;
        rot_phase   = 2'd0;
        rot_count   = 16'd0;
        blink_right = 1'b0;
        blink_count = 16'd0;
        sel_state   = SEL_IDLE;
        hold_count  = 8'd0;
        pitch_sel   = 3'd0;
        tone_on     = 1'b1;
        tone_count  = 8'd0;
    endtask

    // one tick through rotator, blinker, selector and tone, in that order
    task automatic step_sequencer(input logic up, input logic dn, input logic en,
                                  output t_tick_result res);
        logic [31:0] word;
        logic [7:0]  half;

        // rotator
        if (rot_phase > 2'd2) begin
            rot_phase = 2'd0;
        end else if (rot_count == model_cfg.phase_ticks) begin
            rot_phase = (rot_phase == 2'd2) ? 2'd0 : rot_phase + 2'd1;
            rot_count = 16'd0;
        end
        rot_count = rot_count + 16'd1;
        res.port_value = 5'd1 << rot_phase;

        // blinker
        if (blink_count == model_cfg.blink_ticks) begin
            blink_right = ~blink_right;
            blink_count = 16'd0;
        end
        blink_count = blink_count + 16'd1;
        res.port_value = res.port_value | (blink_right ? BLINK_RIGHT : BLINK_LEFT);

        // selector transition, then the action of the new state
        case (sel_state)
            SEL_IDLE: begin
                if (up && !dn) sel_state = SEL_UP;
                else if (dn && !up) sel_state = SEL_DOWN;
            end
            SEL_UP, SEL_DOWN: sel_state = SEL_WAIT;
            default: begin
                if (hold_count >= model_cfg.hold_ticks && !up && !dn) sel_state = SEL_IDLE;
            end
        endcase
        case (sel_state)
            SEL_IDLE: hold_count = 8'd0;
            SEL_UP:   if (pitch_sel < PITCH_MAX) pitch_sel = pitch_sel + 3'd1;
            SEL_DOWN: if (pitch_sel != 3'd0) pitch_sel = pitch_sel - 3'd1;
            default:  hold_count = hold_count + 8'd1;
        endcase

        // tone uses the pitch as updated on this tick
        word = pitch_sel[2] ? model_cfg.pitch_high : model_cfg.pitch_low;
        half = word[{pitch_sel[1:0], 3'b000} +: 8];
        if (tone_on) begin
            if (tone_count == half) begin
                tone_on    = 1'b0;
                tone_count = 8'd0;
            end
        end else if (en && tone_count == half) begin
            tone_on    = 1'b1;
            tone_count = 8'd0;
        end
        tone_count = tone_count + 8'd1;
        if (tone_on) res.port_value = res.port_value | TONE_BIT;
        res.pitch_index = pitch_sel;
    endtask

    // offer one tick transaction and record its expected result once accepted
    task automatic send_tick(input logic up, input logic dn, input logic en,
                             input logic use_typed, input t_tick_result typed_res);
        int unsigned  gap;
        t_tick_result res;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_button_up    <= up;
        i_button_down  <= dn;
        i_sound_enable <= en;
        do @(posedge i_clk); while (o_stall);
        step_sequencer(up, dn, en, res);
        pending_results.push_back(use_typed ? typed_res : res);
        ticks_sent++;
    endtask

    // stop offering ticks and let every result drain
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // apb write with readback, only while nothing is in flight
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        logic [31:0] want;
        logic [31:0] got;
        wait_idle();
        case (idx)
            REG_PHASE_TICKS: begin
                model_cfg.phase_ticks = val[15:0];
                want = {16'h0, val[15:0]};
            end
            REG_BLINK_TICKS: begin
                model_cfg.blink_ticks = val[15:0];
                want = {16'h0, val[15:0]};
            end
            REG_HOLD_TICKS: begin
                model_cfg.hold_ticks = val[7:0];
                want = {24'h0, val[7:0]};
            end
            REG_PITCH_LOW: begin
                model_cfg.pitch_low = val;
                want = val;
            end
            default: begin
                model_cfg.pitch_high = val;
                want = val;
            end
        endcase
        // write: setup then access
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // read back
        @(posedge i_clk);
        psel    <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got != want) begin
            $error("register %0d readback: expected %0h, actual %0h", idx, want, got);
            readback_errs++;
        end
    endtask

    // press sequences with random content, plus some noise
    task automatic run_gestures(input int unsigned n_items);
        int unsigned target;
        int unsigned len;
        int unsigned span;
        int unsigned k;
        logic        dir;
        logic        bias;
        target = ticks_sent + n_items;
        while (ticks_sent < target) begin
            bias = ($urandom_range(0, 1) != 0);
            if ($urandom_range(0, 9) < 7) begin
                // lone press held a few ticks, then an idle run that may be empty
                dir = ($urandom_range(0, 1) != 0);
                len = $urandom_range(1, 4);
                for (k = 0; k < len; k++) send_tick(dir, ~dir, pick_enable(bias), 1'b0, '0);
                span = int'(model_cfg.hold_ticks) + 3;
                if (span > 12) span = 12;
                len = $urandom_range(0, span);
                for (k = 0; k < len; k++) send_tick(1'b0, 1'b0, pick_enable(bias), 1'b0, '0);
            end else begin
                // random buttons, both pressed included
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++) begin
                    send_tick($urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0,
                              $urandom_range(0, 1) != 0, 1'b0, '0);
                end
            end
        end
    endtask

    // result side: check each accepted result, drive random stall
    initial begin : result_side
        int unsigned  stall_left;
        int unsigned  run_left;
        t_tick_result want;
        logic         hold_off_done;
        stall_left    = 0;
        run_left      = 0;
        hold_off_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: port_value %0h, pitch_index %0h",
                           o_port_value, o_pitch_index);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_port_value != want.port_value) begin
                        $error("port_value: expected %0h, actual %0h",
                               want.port_value, o_port_value);
                        mismatch_count++;
                    end
                    if (o_pitch_index != want.pitch_index) begin
                        $error("pitch_index: expected %0h, actual %0h",
                               want.pitch_index, o_pitch_index);
                        mismatch_count++;
                    end
                end
            end
            // long hold-off so the block fills and stalls its input
            if (hold_off_req && !hold_off_done) begin
                stall_left    = 300;
                hold_off_done = 1'b1;
            end
            if (stall_left != 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (run_left != 0 || rx_quiet) begin
                if (run_left != 0) run_left--;
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
                stall_left = pick_gap();
                run_left   = $urandom_range(0, 12);
            end
        end
    end

    // stimulus
    initial begin : stimulus
        int unsigned r;
        reset_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (r = 0; r < DirRows; r++) begin
            if (dir_table[r].kind == ROW_WRITE) begin
                write_reg(dir_table[r].reg_idx, dir_table[r].data);
            end else begin
                send_tick(dir_table[r].up, dir_table[r].dn, dir_table[r].en,
                          dir_table[r].typed, dir_table[r].want);
            end
        end

        // short periods near the running counts
        write_reg(REG_PHASE_TICKS, {16'h0, rot_count + 16'($urandom_range(0, 4))});
        write_reg(REG_BLINK_TICKS, {16'h0, blink_count + 16'($urandom_range(0, 6))});
        write_reg(REG_HOLD_TICKS, 32'($urandom_range(0, 3)));
        write_reg(REG_PITCH_LOW, small_table(9));
        write_reg(REG_PITCH_HIGH, small_table(9));
        run_gestures(250);

        // extremes: longest phase and hold, zero blink period, no idling on either side
        write_reg(REG_PHASE_TICKS, 32'h0000_FFFF);
        write_reg(REG_BLINK_TICKS, 32'h0000_0000);
        write_reg(REG_HOLD_TICKS, 32'h0000_00FF);
        write_reg(REG_PITCH_LOW, 32'hFFFF_FFFF);
        write_reg(REG_PITCH_HIGH, 32'h0000_0000);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        run_gestures(150);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        // opposite extremes: zero phase and hold, longest blink, with a long receiver hold-off
        write_reg(REG_PHASE_TICKS, 32'h0000_0000);
        write_reg(REG_BLINK_TICKS, 32'h0000_FFFF);
        write_reg(REG_HOLD_TICKS, 32'h0000_0000);
        write_reg(REG_PITCH_LOW, 32'h00FF_00FF);
        write_reg(REG_PITCH_HIGH, 32'hFF00_FF00);
        hold_off_req = 1'b1;
        run_gestures(150);

        // random mid-range setting
        write_reg(REG_PHASE_TICKS, {16'h0, rot_count + 16'($urandom_range(0, 10))});
        write_reg(REG_BLINK_TICKS, {16'h0, blink_count + 16'($urandom_range(0, 10))});
        write_reg(REG_HOLD_TICKS, 32'($urandom_range(0, 8)));
        write_reg(REG_PITCH_LOW, small_table(15));
        write_reg(REG_PITCH_HIGH, small_table(15));
        run_gestures(150);

        wait_idle();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && readback_errs == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
